// File: rtl/tccc_pkg.sv
// tccc_pkg: shared types and constants of the text console cursor control block
// no dependencies; used by every module under rtl

package tccc_pkg;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TEXT_COLOR   = 2'd0;
    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd1;
    localparam logic [1:0] CFG_SCROLL_ROW   = 2'd2;

    // configuration reset values
    localparam logic [7:0] TEXT_COLOR_RST   = 8'h0F;
    localparam logic [7:0] SCREEN_WIDTH_RST = 8'd80;
    localparam logic [7:0] SCROLL_ROW_RST   = 8'd24;

    // control characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] TAB_STEP   = 8'd4;
    localparam logic [7:0] SCROLL_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] text_color;
        logic [7:0] screen_width;
        logic [7:0] scroll_row;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [7:0] new_col;
        logic [7:0] new_row;
    } item_t;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_char;
        logic [7:0] write_attr;
        logic [7:0] write_col;
        logic [7:0] write_row;
        logic       clear_screen;
        logic [7:0] scroll_lines;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } result_t;

endpackage

// File: rtl/tccc_cfg.sv
// tccc_cfg: configuration registers (text color, screen width, scroll row)
// depends on tccc_pkg

module tccc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [7:0]          wr_data,
    output tccc_pkg::cfg_t      cfg
);

    tccc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_color   <= tccc_pkg::TEXT_COLOR_RST;
            cfg_reg.screen_width <= tccc_pkg::SCREEN_WIDTH_RST;
            cfg_reg.scroll_row   <= tccc_pkg::SCROLL_ROW_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tccc_pkg::CFG_TEXT_COLOR:   cfg_reg.text_color   <= wr_data;
                tccc_pkg::CFG_SCREEN_WIDTH: cfg_reg.screen_width <= wr_data;
                tccc_pkg::CFG_SCROLL_ROW:   cfg_reg.scroll_row   <= wr_data;
                default:                    ; // no register there
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tccc_cursor.sv
// tccc_cursor: cursor position registers and the per-word update logic
// depends on tccc_pkg

module tccc_cursor #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  tccc_pkg::item_t     item,
    input  tccc_pkg::cfg_t      cfg,
    output tccc_pkg::result_t   res
);

    // wide enough for position + tab step and for 8-bit config compares
    localparam int CALC_W = (COORD_WIDTH >= 8) ? COORD_WIDTH + 1 : 9;

    logic [COORD_WIDTH-1:0] col_pos_reg;
    logic [COORD_WIDTH-1:0] row_pos_reg;
    logic [COORD_WIDTH-1:0] col_pos_next;
    logic [COORD_WIDTH-1:0] row_pos_next;

    logic [CALC_W-1:0] col;
    logic [CALC_W-1:0] row;
    logic [CALC_W-1:0] col_w;
    logic [CALC_W-1:0] row_w;
    logic [CALC_W-1:0] width_ext;
    logic [CALC_W-1:0] scroll_ext;
    logic [CALC_W-1:0] excess;

    assign col        = CALC_W'(col_pos_reg);
    assign row        = CALC_W'(row_pos_reg);
    assign width_ext  = CALC_W'(cfg.screen_width);
    assign scroll_ext = CALC_W'(cfg.scroll_row);

    always_comb
    begin
        res          = '0;
        col_w        = col;
        row_w        = row;
        excess       = '0;
        case (item.mode)
            tccc_pkg::MODE_PUT:
            begin
                case (item.char_code)
                    tccc_pkg::CH_CR, tccc_pkg::CH_LF:
                    begin
                        col_w = '0;
                        row_w = row + CALC_W'(1);
                    end
                    tccc_pkg::CH_TAB:
                    begin
                        col_w = col + CALC_W'(tccc_pkg::TAB_STEP);
                    end
                    tccc_pkg::CH_VT:
                    begin
                        row_w = row + CALC_W'(1);
                    end
                    tccc_pkg::CH_BS:
                    begin
                        // backspace blanks the cell it steps back onto
                        if (col != '0)
                        begin
                            col_w           = col - CALC_W'(1);
                            res.write_valid = 1'b1;
                            res.write_char  = tccc_pkg::CH_SPACE;
                            res.write_attr  = cfg.text_color;
                            res.write_col   = col_w[7:0];
                            res.write_row   = row[7:0];
                        end
                    end
                    tccc_pkg::CH_FF:
                    begin
                        res.clear_screen = 1'b1;
                        col_w            = '0;
                        row_w            = '0;
                    end
                    default:
                    begin
                        res.write_valid = 1'b1;
                        res.write_char  = item.char_code;
                        res.write_attr  = cfg.text_color;
                        res.write_col   = col[7:0];
                        res.write_row   = row[7:0];
                        col_w           = col + CALC_W'(1);
                    end
                endcase
                // wrap at the right edge
                if (col_w >= width_ext)
                begin
                    col_w = '0;
                    row_w = row_w + CALC_W'(1);
                end
                // clamp at the scroll row and report the excess
                if (row_w > scroll_ext)
                begin
                    excess = row_w - scroll_ext;
                    if (excess > CALC_W'(tccc_pkg::SCROLL_MAX))
                        res.scroll_lines = tccc_pkg::SCROLL_MAX;
                    else
                        res.scroll_lines = excess[7:0];
                    row_w = scroll_ext;
                end
            end
            tccc_pkg::MODE_SET:
            begin
                col_w = CALC_W'(item.new_col);
                row_w = CALC_W'(item.new_row);
            end
            tccc_pkg::MODE_CLEAR:
            begin
                res.clear_screen = 1'b1;
                col_w            = '0;
                row_w            = '0;
            end
            default:
            begin
                // unused code leaves everything as is
                col_w = col;
                row_w = row;
            end
        endcase
        // reported position is the stored one, cut to the coordinate width
        res.cursor_col = 8'(col_w[COORD_WIDTH-1:0]);
        res.cursor_row = 8'(row_w[COORD_WIDTH-1:0]);
    end

    assign col_pos_next = col_w[COORD_WIDTH-1:0];
    assign row_pos_next = row_w[COORD_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (advance)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

// File: rtl/text_console_cursor_control.sv
// text_console_cursor_control: top level of the text console cursor block
// depends on tccc_pkg, tccc_cfg and tccc_cursor
//
// usage:
//   input channel (in_valid/in_ready) carries one word per operation: mode
//   selects put character, set cursor position or clear screen; char_code,
//   new_col and new_row are its operands
//   output channel (out_valid/out_ready) returns exactly one result word per
//   input word: glyph write request (valid, char, attr, cell), clear-screen
//   flag, lines to scroll up and the cursor position after the operation
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes text
//   color, screen width and scroll row; always ready, write it only while
//   no word is in flight
// timing:
//   two register stages (input word register, result register); an accepted
//   word is held in the input word register, then in the result register
//   one word per cycle sustained while out_ready holds; the cursor update
//   is a single pass of compares and small adds on the cursor registers
// reset: cursor at column 0 row 0, text color 0x0F, width 80, scroll row 24,
//   both pipeline stages empty
// stall:
//   a held result keeps its value; the input stage still takes one more
//   word, after that in_ready drops until out_ready frees the result

module text_console_cursor_control #(
    parameter int COORD_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    // input words
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] char_code,
    input  logic [7:0] new_col,
    input  logic [7:0] new_row,
    // result words
    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_valid,
    output logic [7:0] write_char,
    output logic [7:0] write_attr,
    output logic [7:0] write_col,
    output logic [7:0] write_row,
    output logic       clear_screen,
    output logic [7:0] scroll_lines,
    output logic [7:0] cursor_col,
    output logic [7:0] cursor_row,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic                in_valid_reg;
    tccc_pkg::item_t     in_item_reg;
    logic                out_valid_reg;
    tccc_pkg::result_t   out_res_reg;

    tccc_pkg::cfg_t      cfg;
    tccc_pkg::result_t   step_res;
    tccc_pkg::item_t     in_item;
    logic                advance;
    logic                in_fire;

    assign in_item.mode      = mode;
    assign in_item.char_code = char_code;
    assign in_item.new_col   = new_col;
    assign in_item.new_row   = new_row;

    // a word moves from the input stage into the result stage when the
    // result register is empty or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // registers are always writable
    assign cfg_ready = 1'b1;

    tccc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tccc_cursor #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cursor (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // input word stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_item_reg <= in_item;
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign write_valid  = out_res_reg.write_valid;
    assign write_char   = out_res_reg.write_char;
    assign write_attr   = out_res_reg.write_attr;
    assign write_col    = out_res_reg.write_col;
    assign write_row    = out_res_reg.write_row;
    assign clear_screen = out_res_reg.clear_screen;
    assign scroll_lines = out_res_reg.scroll_lines;
    assign cursor_col   = out_res_reg.cursor_col;
    assign cursor_row   = out_res_reg.cursor_row;

endmodule
